[rtl/core/tcwa_pkg.sv]
// shared types and constants for the centered time-window average
`default_nettype none

package tcwa_pkg;

    localparam int TIME_BITS  = 32;
    localparam int HW_BITS    = 16;
    localparam int COUNT_BITS = 7;
    localparam logic [HW_BITS-1:0] HW_RESET = 16'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FETCH,
        S_CHECK,
        S_TAIL,
        S_SCAN,
        S_DROP,
        S_DIV,
        S_DIV_WAIT,
        S_EMIT,
        S_FULL_DROP,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_EOT,
        PH_FULL
    } t_phase;

endpackage

`default_nettype wire

[rtl/core/time_window_centered_average_core.sv]
// centered time-window average: sample ring of cells, sequencer and serial divider
//
// Samples live in a ring of BUFFER_DEPTH cells, oldest in cell 0; while the sequencer fetches,
// scans or drops, the ring rotates by one cell per cycle, and the sequencer watches cell 0.
// An item is taken only while the block is idle. Each result costs one full rotation to
// fetch its centre, one full rotation to sum the window, one rotation step per sample dropped
// from the front, and a pass through the serial divider; an item that releases nothing still
// takes one rotation per held centre checked. Results leave through an output register and a
// one-deep hold stage that decides last_of_run.
`default_nettype none

module time_window_centered_average_core #(
    parameter int BUFFER_DEPTH = 64,
    parameter int VALUE_BITS   = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [tcwa_pkg::HW_BITS-1:0]     i_cfg_wr_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [tcwa_pkg::TIME_BITS-1:0]   i_sample_time,
    input  wire logic signed [VALUE_BITS-1:0]     i_sample_value,
    input  wire logic                             i_end_of_trace,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [tcwa_pkg::TIME_BITS-1:0]   o_centre_time,
    output logic signed [VALUE_BITS-1:0]          o_smoothed_value,
    output logic      [tcwa_pkg::COUNT_BITS-1:0]  o_window_count,
    output logic                                  o_window_truncated,
    output logic                                  o_last_of_run
);
    import tcwa_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W = VALUE_BITS + CNT_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

    t_state r_state, n_state;
    t_phase r_phase;

    logic [HW_BITS-1:0]    r_hw;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_p;
    logic [CNT_W-1:0]      r_j;
    logic [CNT_W-1:0]      r_d;
    logic [CNT_W-1:0]      r_n;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_dropping;
    logic                  r_stop;
    logic [TIME_BITS-1:0]  r_t;
    logic                  r_eot;
    logic                  r_trunc;
    logic [TIME_BITS-1:0]  r_ct;
    logic [VALUE_BITS-1:0] r_cv;

    logic                  r_hold_valid;
    logic [TIME_BITS-1:0]  r_hold_time;
    logic [VALUE_BITS-1:0] r_hold_value;
    logic [COUNT_BITS-1:0] r_hold_count;
    logic                  r_hold_trunc;

    logic                  r_out_valid;
    logic [TIME_BITS-1:0]  r_out_time;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                  r_out_trunc;
    logic                  r_out_last;

    logic w_accept, w_rot, w_load, w_div_start, w_div_done;
    logic w_pending, w_last_step, w_full, w_slot_free;
    logic signed [SUM_W-1:0] w_quot;
    logic [TIME_BITS:0]    w_upper, w_head_hw;
    logic [TIME_BITS-1:0]  w_cell_time  [BUFFER_DEPTH];
    logic [VALUE_BITS-1:0] w_cell_value [BUFFER_DEPTH];
    logic [VALUE_BITS-1:0] w_mean;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_pending   = r_p < r_cnt;
    assign w_last_step = r_j == DEPTH_C - CNT_W'(1);
    assign w_full      = r_cnt >= DEPTH_C;
    assign w_slot_free = !r_hold_valid || !r_out_valid;
    assign w_upper     = {1'b0, r_ct} + (TIME_BITS+1)'(r_hw);
    assign w_head_hw   = {1'b0, w_cell_time[0]} + (TIME_BITS+1)'(r_hw);
    assign w_mean      = (r_n == '0) ? r_cv : w_quot[VALUE_BITS-1:0];

    // ring of sample cells, each handing its sample to the one below
    for (genvar g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
        localparam int NB = (g + 1) % BUFFER_DEPTH;
        tcwa_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .i_clk      (i_clk),
            .i_rot      (w_rot),
            .i_load     (w_load && (r_cnt == CNT_W'(g))),
            .i_time     (i_sample_time),
            .i_value    (i_sample_value),
            .i_nb_time  (w_cell_time[NB]),
            .i_nb_value (w_cell_value[NB]),
            .o_time     (w_cell_time[g]),
            .o_value    (w_cell_value[g])
        );
    end

    tcwa_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (r_phase)
                    PH_NORMAL: n_state = w_pending ? S_FETCH : S_TAIL;
                    PH_EOT:    n_state = w_pending ? S_FETCH : S_FLUSH;
                    PH_FULL:   n_state = w_full ? S_FULL_DROP : S_FLUSH;
                    default:   n_state = S_FLUSH;
                endcase
            end
            S_FETCH: begin
                if (w_last_step) n_state = (r_phase == PH_NORMAL) ? S_CHECK : S_SCAN;
            end
            S_CHECK:     n_state = ({1'b0, r_t} >= w_upper) ? S_SCAN : S_TAIL;
            S_TAIL: begin
                if (r_eot) n_state = S_DISPATCH;
                else if (w_full) n_state = w_pending ? S_FETCH : S_DISPATCH;
                else n_state = S_FLUSH;
            end
            S_SCAN:      if (w_last_step) n_state = (r_d != '0) ? S_DROP : S_DIV;
            S_DROP:      if (r_d == CNT_W'(1)) n_state = S_DIV;
            S_DIV:       n_state = (r_n == '0) ? S_EMIT : S_DIV_WAIT;
            S_DIV_WAIT:  if (w_div_done) n_state = S_EMIT;
            S_EMIT:      if (w_slot_free) n_state = S_DISPATCH;
            S_FULL_DROP: n_state = S_FLUSH;
            S_FLUSH:     if (w_slot_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_rot       = 1'b0;
        w_load      = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE:      w_load = w_accept;
            S_FETCH:     w_rot = 1'b1;
            S_SCAN:      w_rot = 1'b1;
            S_DROP:      w_rot = 1'b1;
            S_FULL_DROP: w_rot = 1'b1;
            S_DIV:       w_div_start = (r_n != '0);
            default: begin
                w_rot = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_NORMAL;
            r_hw         <= HW_RESET;
            r_cnt        <= '0;
            r_p          <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_hw <= i_cfg_wr_data;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_phase <= PH_NORMAL;
                    end
                end
                S_DISPATCH: begin
                    if (r_phase == PH_EOT && !w_pending) begin
                        r_cnt <= '0;
                        r_p   <= '0;
                    end
                end
                S_TAIL: begin
                    if (r_eot) r_phase <= PH_EOT;
                    else if (w_full) r_phase <= PH_FULL;
                end
                S_DROP, S_FULL_DROP: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    r_p   <= r_p - CNT_W'(1);
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_hold_valid <= 1'b1;
                        r_p          <= r_p + CNT_W'(1);
                        if (r_hold_valid) r_out_valid <= 1'b1;
                    end
                end
                S_FLUSH: begin
                    if (r_hold_valid && !r_out_valid) begin
                        r_hold_valid <= 1'b0;
                        r_out_valid  <= 1'b1;
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_t     <= i_sample_time;
                r_eot   <= i_end_of_trace;
                r_trunc <= 1'b0;
                r_j     <= '0;
            end
            S_DISPATCH: r_j <= '0;
            S_TAIL: begin
                r_j <= '0;
                if (!r_eot && w_full) r_trunc <= 1'b1;
            end
            S_FETCH: begin
                r_j <= w_last_step ? '0 : r_j + CNT_W'(1);
                if (r_j == r_p) begin
                    r_ct <= w_cell_time[0];
                    r_cv <= w_cell_value[0];
                end
                r_sum      <= '0;
                r_n        <= '0;
                r_d        <= '0;
                r_dropping <= 1'b1;
                r_stop     <= 1'b0;
            end
            S_SCAN: begin
                r_j <= w_last_step ? '0 : r_j + CNT_W'(1);
                if (r_j < r_cnt) begin
                    // leading samples too old for this centre, never the centre itself
                    if (r_dropping && r_j < r_p && w_head_hw < {1'b0, r_ct}) begin
                        r_d <= r_d + CNT_W'(1);
                    end else begin
                        r_dropping <= 1'b0;
                        if (!r_stop) begin
                            if ({1'b0, w_cell_time[0]} >= w_upper) begin
                                r_stop <= 1'b1;
                            end else begin
                                r_sum <= r_sum + {{(SUM_W-VALUE_BITS){w_cell_value[0][VALUE_BITS-1]}},
                                                  w_cell_value[0]};
                                r_n   <= r_n + CNT_W'(1);
                            end
                        end
                    end
                end
            end
            S_DROP: r_d <= r_d - CNT_W'(1);
            S_EMIT: begin
                r_j <= '0;
                if (w_slot_free) begin
                    if (r_hold_valid) begin
                        r_out_time  <= r_hold_time;
                        r_out_value <= r_hold_value;
                        r_out_count <= r_hold_count;
                        r_out_trunc <= r_hold_trunc;
                        r_out_last  <= 1'b0;
                    end
                    r_hold_time  <= r_ct;
                    r_hold_value <= w_mean;
                    r_hold_count <= COUNT_BITS'(r_n);
                    r_hold_trunc <= r_trunc;
                end
            end
            S_FLUSH: begin
                if (r_hold_valid && !r_out_valid) begin
                    r_out_time  <= r_hold_time;
                    r_out_value <= r_hold_value;
                    r_out_count <= r_hold_count;
                    r_out_trunc <= r_hold_trunc;
                    r_out_last  <= 1'b1;
                end
            end
            default: begin
                r_j <= r_j;
            end
        endcase
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_centre_time      = r_out_time;
    assign o_smoothed_value   = r_out_value;
    assign o_window_count     = r_out_count;
    assign o_window_truncated = r_out_trunc;
    assign o_last_of_run      = r_out_last;

endmodule

`default_nettype wire

[rtl/core/tcwa_cell.sv]
// one sample cell of the rotating sample ring
`default_nettype none

module tcwa_cell #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rot,
    input  wire logic                           i_load,
    input  wire logic [tcwa_pkg::TIME_BITS-1:0] i_time,
    input  wire logic [VALUE_BITS-1:0]          i_value,
    input  wire logic [tcwa_pkg::TIME_BITS-1:0] i_nb_time,
    input  wire logic [VALUE_BITS-1:0]          i_nb_value,
    output logic      [tcwa_pkg::TIME_BITS-1:0] o_time,
    output logic      [VALUE_BITS-1:0]          o_value
);
    import tcwa_pkg::*;

    logic [TIME_BITS-1:0]  r_time;
    logic [VALUE_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_time  <= i_time;
            r_value <= i_value;
        end else if (i_rot) begin
            r_time  <= i_nb_time;
            r_value <= i_nb_value;
        end
    end

    assign o_time  = r_time;
    assign o_value = r_value;

endmodule

`default_nettype wire

[rtl/core/tcwa_div.sv]
// serial restoring divider, signed dividend by unsigned divisor, truncating toward zero
`default_nettype none

module tcwa_div #(
    parameter int SUM_W = 23,
    parameter int CNT_W = 7
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_dividend,
    input  wire logic        [CNT_W-1:0] i_divisor,
    output logic                         o_done,
    output logic signed      [SUM_W-1:0] o_quot
);
    import tcwa_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_q;
    logic              r_neg;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    w_sh;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_q[SUM_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_div};
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[SUM_W-1] ? -i_dividend : i_dividend;
            r_neg <= i_dividend[SUM_W-1];
            r_rem <= '0;
            r_div <= i_divisor;
            r_step <= STEP_W'(SUM_W);
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_sh[CNT_W-1:0];
            r_q    <= {r_q[SUM_W-2:0], w_ge};
            r_step <= r_step - STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -r_q : r_q;

endmodule

`default_nettype wire

[bench/tb_time_window_centered_average_core.sv]
// testbench for the centered time-window average core: directed table, random traces, scoreboard
`timescale 1ns / 1ps

module tb_time_window_centered_average_core;
    import tcwa_pkg::*;

    localparam int DEPTH      = 64;
    localparam int VBITS      = 16;
    localparam int SETTLE     = 400;
    localparam int HOLD_OFF   = 3000;
    localparam longint LIMIT  = 40000000;

    typedef struct {
        logic [TIME_BITS-1:0]  centre_time;
        logic signed [15:0]    smoothed;
        logic [COUNT_BITS-1:0] count;
        logic                  truncated;
        logic                  last;
    } t_avg_result;

    typedef struct {
        bit                    do_cfg;
        logic [HW_BITS-1:0]    cfg;
        logic [TIME_BITS-1:0]  t;
        logic signed [15:0]    v;
        bit                    eot;
        bit                    typed;
        logic [TIME_BITS-1:0]  e_ct;
        logic signed [15:0]    e_sv;
        logic [COUNT_BITS-1:0] e_cnt;
    } t_dir_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [HW_BITS-1:0]          i_cfg_wr_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [TIME_BITS-1:0]        i_sample_time;
    logic signed [VBITS-1:0]     i_sample_value;
    logic                        i_end_of_trace;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [TIME_BITS-1:0]        o_centre_time;
    logic signed [VBITS-1:0]     o_smoothed_value;
    logic [COUNT_BITS-1:0]       o_window_count;
    logic                        o_window_truncated;
    logic                        o_last_of_run;

    time_window_centered_average_core #(.BUFFER_DEPTH(DEPTH), .VALUE_BITS(VBITS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_sample_time(i_sample_time), .i_sample_value(i_sample_value),
        .i_end_of_trace(i_end_of_trace),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_centre_time(o_centre_time), .o_smoothed_value(o_smoothed_value),
        .o_window_count(o_window_count), .o_window_truncated(o_window_truncated),
        .o_last_of_run(o_last_of_run)
    );

    // predictor state: sample ring and window pointers
    logic [TIME_BITS-1:0] ring_time [DEPTH];
    int                   ring_val  [DEPTH];
    int unsigned          ring_oldest, ring_count, ring_centre;
    logic [HW_BITS-1:0]   half_win;

    t_avg_result pending_results[$];

    int     mismatches = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     truncated_seen = 0;
    int     widest_window = 0;
    int     burst_left = 0;
    bit     hold_off = 0;
    longint cycles = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned ring_next(int unsigned i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    function automatic t_avg_result average_centre(bit trunc);
        t_avg_result r;
        int unsigned c, i, n;
        longint upper, sum;
        c = ring_centre;
        upper = longint'(ring_time[c]) + half_win;
        while (ring_oldest != c && ring_count > 0 &&
               longint'(ring_time[ring_oldest]) + half_win < longint'(ring_time[c])) begin
            ring_oldest = ring_next(ring_oldest);
            ring_count--;
        end
        sum = 0;
        n = 0;
        i = ring_oldest;
        for (int j = 0; j < ring_count; j++) begin
            if (longint'(ring_time[i]) >= upper)
                break;
            sum += ring_val[i];
            n++;
            i = ring_next(i);
        end
        r.centre_time = ring_time[c];
        r.smoothed = (n > 0) ? 16'(sum / longint'(n)) : 16'(ring_val[c]);
        r.count = 7'(n);
        r.truncated = trunc;
        r.last = 0;
        ring_centre = ring_next(c);
        return r;
    endfunction

    // advance the predictor by one sample; queue its results unless told otherwise
    function automatic void predict_sample(logic [31:0] t, logic signed [15:0] v, bit eot,
                                           bit keep);
        t_avg_result batch[$];
        int unsigned off, waiting, w;
        off = (ring_centre + DEPTH - ring_oldest) % DEPTH;
        waiting = (off <= ring_count) ? ring_count - off : 0;
        while (ring_count >= DEPTH) begin
            ring_oldest = ring_next(ring_oldest);
            ring_count--;
        end
        w = (ring_oldest + ring_count) % DEPTH;
        ring_time[w] = t;
        ring_val[w] = v;
        ring_count++;
        waiting++;
        while (waiting > 0 &&
               longint'(t) >= longint'(ring_time[ring_centre]) + half_win) begin
            batch.push_back(average_centre(0));
            waiting--;
        end
        if (eot) begin
            while (waiting > 0) begin
                batch.push_back(average_centre(0));
                waiting--;
            end
            ring_oldest = 0;
            ring_count = 0;
            ring_centre = 0;
        end else if (ring_count >= DEPTH) begin
            if (waiting > 0) begin
                batch.push_back(average_centre(1));
                waiting--;
            end
            if (ring_count >= DEPTH) begin
                ring_oldest = ring_next(ring_oldest);
                ring_count--;
            end
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1;
        if (keep)
            foreach (batch[k]) pending_results.push_back(batch[k]);
    endfunction

    task automatic send_sample(logic [31:0] t, logic signed [15:0] v, bit eot,
                               bit typed = 0, t_avg_result typed_res = '{default: 0});
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1;
        i_sample_time <= t;
        i_sample_value <= v;
        i_end_of_trace <= eot;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        predict_sample(t, v, eot, !typed);
        if (typed)
            pending_results.push_back(typed_res);
    endtask

    task automatic write_half_window(logic [HW_BITS-1:0] hw);
        i_in_valid <= 0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= hw;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        half_win = hw;
        burst_left = 0;
    endtask

    // one trace: mostly well-formed nondecreasing timestamps, some noise, ends with end of trace
    task automatic send_trace(int len);
        logic [31:0] t;
        int unsigned span;
        span = (half_win == 0) ? 3 : (half_win > 1000) ? 50 : 2 * half_win;
        t = $urandom;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0)
                t = $urandom;
            else if ($urandom_range(0, 4) != 0)
                t = t + $urandom_range(0, span);
            send_sample(t, 16'($urandom), k == len - 1);
        end
    endtask

    // receiver: stall pattern and scoreboard
    always @(posedge i_clk) begin
        t_avg_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_window_truncated) truncated_seen++;
            if (int'(o_window_count) > widest_window) widest_window = o_window_count;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: centre %h value %0d count %0d",
                             o_centre_time, o_smoothed_value, o_window_count);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_centre_time !== exp_r.centre_time || o_smoothed_value !== exp_r.smoothed ||
                    o_window_count !== exp_r.count || o_window_truncated !== exp_r.truncated ||
                    o_last_of_run !== exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%0d/%b/%b got %h/%0d/%0d/%b/%b",
                                 exp_r.centre_time, exp_r.smoothed, exp_r.count,
                                 exp_r.truncated, exp_r.last, o_centre_time,
                                 o_smoothed_value, o_window_count, o_window_truncated,
                                 o_last_of_run);
                end
            end
        end
        // stall mode flips now and then so some stretches run without stalls
        i_out_stall <= hold_off || (((cycles / 500) % 2 == 1) && $urandom_range(0, 2) == 0);
    end

    // long receiver hold-off so the core backs up into its input
    initial begin
        wait (items_sent >= 200);
        @(posedge i_clk);
        hold_off <= 1;
        repeat (HOLD_OFF) @(posedge i_clk);
        hold_off <= 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("time_window_centered_average_core verification failed");
            $finish;
        end
    end

    initial begin
        t_dir_row rows[15];
        logic [HW_BITS-1:0] hw_list[6];
        t_avg_result tr;
        int len;

        rows = '{
            '{0, 16'd0,     32'd10,         16'sd5,      1, 1, 32'd10,         16'sd5,      7'd1},
            '{0, 16'd0,     32'd0,          -16'sd32768, 1, 1, 32'd0,          -16'sd32768, 7'd1},
            '{0, 16'd0,     32'hFFFF_FFFF,  16'sd32767,  1, 1, 32'hFFFF_FFFF,  16'sd32767,  7'd1},
            '{0, 16'd0,     32'd100,        -16'sd3,     0, 0, 32'd0, 16'sd0, 7'd0},
            '{0, 16'd0,     32'd100,        16'sd4,      0, 0, 32'd0, 16'sd0, 7'd0},
            '{0, 16'd0,     32'd101,        16'sd1,      0, 0, 32'd0, 16'sd0, 7'd0},
            '{0, 16'd0,     32'd99,         -16'sd7,     0, 0, 32'd0, 16'sd0, 7'd0},
            '{0, 16'd0,     32'd105,        16'sd7,      1, 0, 32'd0, 16'sd0, 7'd0},
            '{1, 16'd0,     32'd7,          -16'sd1,     0, 1, 32'd7,          -16'sd1,     7'd0},
            '{0, 16'd0,     32'd7,          16'sd2,      1, 1, 32'd7,          16'sd2,      7'd0},
            '{1, 16'hFFFF,  32'd50,         16'sd32767,  0, 0, 32'd0, 16'sd0, 7'd0},
            '{0, 16'd0,     32'd60,         16'sd32767,  0, 0, 32'd0, 16'sd0, 7'd0},
            '{0, 16'd0,     32'd70,         16'sd32767,  0, 0, 32'd0, 16'sd0, 7'd0},
            '{0, 16'd0,     32'd80,         -16'sd32768, 0, 0, 32'd0, 16'sd0, 7'd0},
            '{0, 16'd0,     32'd80,         -16'sd32768, 1, 0, 32'd0, 16'sd0, 7'd0}
        };
        hw_list = '{16'hFFFF, 16'd3, 16'd0, 16'd40, 16'd1, 16'd0};
        hw_list[5] = 16'($urandom_range(2, 300));

        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = '0;
        i_in_valid = 0;
        i_sample_time = '0;
        i_sample_value = '0;
        i_end_of_trace = 0;
        ring_oldest = 0;
        ring_count = 0;
        ring_centre = 0;
        half_win = HW_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].do_cfg)
                write_half_window(rows[r].cfg);
            tr = '{rows[r].e_ct, rows[r].e_sv, rows[r].e_cnt, 1'b0, 1'b1};
            send_sample(rows[r].t, rows[r].v, rows[r].eot, rows[r].typed, tr);
        end

        foreach (hw_list[p]) begin
            write_half_window(hw_list[p]);
            len = 0;
            while (len < 68) begin
                case ($urandom_range(0, 9))
                    0, 1:    send_trace($urandom_range(60, 90));
                    2:       send_trace(1);
                    default: send_trace($urandom_range(2, 20));
                endcase
                len = len + 1 + (items_sent % 13);
                len = items_sent - 15 - p * 68 >= 0 ? items_sent - 15 - p * 68 : len;
            end
        end

        i_in_valid <= 0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d samples sent over the directed table and six random window settings",
                 items_sent);
        $display("%0d results checked, %0d early releases on a full buffer, widest window %0d",
                 results_seen, truncated_seen, widest_window);
        if (mismatches == 0)
            $display("time_window_centered_average_core verification clean");
        else
            $display("time_window_centered_average_core verification failed");
        $finish;
    end

endmodule
